[design/jacobi_linear_solver_macros.svh]
// Assertion macros shared by the solver RTL.
// Depends on a clock named clock and a reset named reset in the using module.
`ifndef JACOBI_LINEAR_SOLVER_MACROS_SVH
`define JACOBI_LINEAR_SOLVER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define JLS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define JLS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[design/jls_pkg.sv]
// Package for the Jacobi solver: sizes, codes, payload and control types.
// No dependencies.
package jls_pkg;

   localparam int MAX_ORDER = 64;
   localparam int IDX_W = $clog2(MAX_ORDER);
   localparam int ORDER_W = IDX_W + 1;
   localparam int FRACTION_BITS = 16;
   localparam int DATA_W = 32;
   localparam int ACC_W = 2 * DATA_W;
   localparam int ITER_W = 16;
   localparam int CSR_ADDR_W = 3;

   localparam logic [1:0] OP_LOAD_MATRIX = 2'd0;
   localparam logic [1:0] OP_LOAD_RHS = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;

   localparam logic CSR_ITER_LIMIT = 1'b0;
   localparam logic CSR_ORDER = 1'b1;

   typedef struct packed {
      logic [1:0] operation;
      logic [IDX_W-1:0] row_index;
      logic [IDX_W-1:0] column_index;
      logic signed [DATA_W-1:0] entry_value;
   } req_payload_type;

   typedef struct packed {
      logic [IDX_W-1:0] unknown_index;
      logic signed [DATA_W-1:0] solution_value;
      logic last_entry;
      logic zero_diagonal_error;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic sub;
   } mac_ctrl_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIAG,
      S_DIAG_CHK,
      S_ROW_BEGIN,
      S_ROW_LOAD,
      S_TERM_RD,
      S_TERM_MUL,
      S_TERM_ACC,
      S_DIV_RD,
      S_DIV_GO,
      S_DIV_WAIT,
      S_EMIT_RD,
      S_EMIT_OUT
   } state_type;

endpackage

[design/jls_mac.sv]
// Shared multiply and saturating 64-bit accumulate unit.
// Depends on jls_pkg.
module jls_mac
   import jls_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  mac_ctrl_type ctrl,
   input  logic signed [ACC_W-1:0] load_value,
   input  logic signed [DATA_W-1:0] mul_a,
   input  logic signed [DATA_W-1:0] mul_b,
   output logic signed [ACC_W-1:0] acc
);

   logic signed [ACC_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W:0] diff;

   always_comb begin
      diff = {acc_ff[ACC_W-1], acc_ff} - {prod_ff[ACC_W-1], prod_ff};
      prod_in = prod_ff;
      acc_in = acc_ff;
      if (ctrl.mul) begin
         prod_in = mul_a * mul_b;
      end
      if (ctrl.load) begin
         acc_in = load_value;
      end else if (ctrl.sub) begin
         if (diff[ACC_W] != diff[ACC_W-1]) begin
            acc_in = diff[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
         end else begin
            acc_in = diff[ACC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

[design/jls_div.sv]
// Bit-serial signed divider: 64-bit numerator by 32-bit denominator,
// truncating quotient saturated to 32 bits. Depends on jls_pkg.
module jls_div
   import jls_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [ACC_W-1:0] numer,
   input  logic signed [DATA_W-1:0] denom,
   output logic done,
   output logic signed [DATA_W-1:0] quotient
);

   localparam int CNT_W = $clog2(ACC_W);

   logic busy_ff, busy_in;
   logic fin_ff, fin_in;
   logic done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic neg_ff, neg_in;
   logic [ACC_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic [DATA_W:0] rem_sh;
   logic [DATA_W:0] rem_dif;
   logic ge;
   logic big;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[ACC_W-1]};
      rem_dif = rem_sh - {1'b0, den_ff};
      ge = rem_sh >= {1'b0, den_ff};
      big = |quo_ff[ACC_W-1:DATA_W-1];
      busy_in = busy_ff;
      fin_in = 1'b0;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      res_in = res_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         neg_in = numer[ACC_W-1] ^ denom[DATA_W-1];
         quo_in = numer[ACC_W-1] ? (~numer + 1'b1) : numer;
         den_in = denom[DATA_W-1] ? (~denom + 1'b1) : denom;
         rem_in = '0;
      end else if (busy_ff) begin
         rem_in = ge ? rem_dif[DATA_W-1:0] : rem_sh[DATA_W-1:0];
         quo_in = {quo_ff[ACC_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ACC_W - 1)) begin
            busy_in = 1'b0;
            fin_in = 1'b1;
         end
      end else if (fin_ff) begin
         done_in = 1'b1;
         if (neg_ff) begin
            res_in = big ? {1'b1, {(DATA_W-1){1'b0}}} : (~quo_ff[DATA_W-1:0] + 1'b1);
         end else begin
            res_in = big ? {1'b0, {(DATA_W-1){1'b1}}} : quo_ff[DATA_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      res_ff <= res_in;
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff <= fin_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = res_ff;

endmodule

[design/jacobi_linear_solver.sv]
// Top level of the Jacobi solver: stores, sequencer, config registers.
// Depends on jls_pkg, jls_mac, jls_div and jacobi_linear_solver_macros.svh.
//
// Usage: load A[r][c] (operation 0) and b[r] (operation 1) one transaction
// per cycle on the req_ channel, then send a start (operation 2). Loads give
// no result. A start runs the solver and then emits matrix_order (clamped to
// 1..64) transactions on the rsp_ channel in index order, last_entry set on
// the final one. The shared multiplier and the one-bit-per-cycle divider
// (64 steps) set the solve time. req_stall is high from the start until the
// last result sits in the output register; loads are taken every cycle
// when idle. A zero diagonal skips the sweeps and gives one zero result per
// unknown with zero_diagonal_error set. rsp_stall holds the output register;
// the sequencer waits for it. Synchronous reset clears control state and sets
// iteration_limit to 1 and matrix_order to 64; stores are undefined.
`include "jacobi_linear_solver_macros.svh"
module jacobi_linear_solver
   import jls_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  req_payload_type req_payload,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   localparam int MEM_DEPTH = MAX_ORDER * MAX_ORDER;

   logic signed [DATA_W-1:0] mat_mem [0:MEM_DEPTH-1];
   logic signed [DATA_W-1:0] rhs_mem [0:MAX_ORDER-1];
   logic signed [DATA_W-1:0] est0_mem [0:MAX_ORDER-1];
   logic signed [DATA_W-1:0] est1_mem [0:MAX_ORDER-1];

   state_type state_ff, state_in;
   logic [IDX_W-1:0] row_ff, row_in;
   logic [IDX_W-1:0] col_ff, col_in;
   logic [ITER_W-1:0] sweep_ff, sweep_in;
   logic [ORDER_W-1:0] n_ff, n_in;
   logic err_ff, err_in;
   logic bank_ff, bank_in;
   logic init_ff, init_in;
   logic [ITER_W-1:0] iter_limit_ff, iter_limit_in;
   logic [ORDER_W-1:0] order_ff, order_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic signed [DATA_W-1:0] mat_rd_ff;
   logic signed [DATA_W-1:0] rhs_rd_ff;
   logic signed [DATA_W-1:0] est_rd_ff;

   logic req_acc;
   logic csr_wr;
   logic diag_rd;
   logic [IDX_W-1:0] mat_col;
   logic est_we;
   logic est_wbank;
   logic last_row;
   logic last_col;
   logic [ITER_W-1:0] next_sweep;
   logic [ORDER_W-1:0] n_clamp;

   mac_ctrl_type mac_ctrl;
   logic signed [ACC_W-1:0] mac_load;
   logic signed [ACC_W-1:0] acc;
   logic div_start;
   logic div_done;
   logic signed [DATA_W-1:0] div_q;

   jls_mac u_mac (
      .clock(clock),
      .reset(reset),
      .ctrl(mac_ctrl),
      .load_value(mac_load),
      .mul_a(mat_rd_ff),
      .mul_b(est_rd_ff),
      .acc(acc)
   );

   jls_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .numer(acc),
      .denom(mat_rd_ff),
      .done(div_done),
      .quotient(div_q)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc = req_valid && !req_stall;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign diag_rd = (state_ff == S_DIAG) || (state_ff == S_DIV_RD);
   assign mat_col = diag_rd ? row_ff : col_ff;
   assign est_wbank = init_ff ? bank_ff : ~bank_ff;
   assign last_row = ({1'b0, row_ff} == n_ff - 1'b1);
   assign last_col = ({1'b0, col_ff} == n_ff - 1'b1);
   assign next_sweep = init_ff ? sweep_ff : sweep_ff + 1'b1;
   assign n_clamp = (order_ff == '0) ? ORDER_W'(1) :
                    (order_ff > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order_ff;
   assign mac_load = ACC_W'(rhs_rd_ff) <<< FRACTION_BITS;

   // stores
   always_ff @(posedge clock) begin
      if (req_acc && req_payload.operation == OP_LOAD_MATRIX) begin
         mat_mem[{req_payload.row_index, req_payload.column_index}] <= req_payload.entry_value;
      end
      mat_rd_ff <= mat_mem[{row_ff, mat_col}];
   end

   always_ff @(posedge clock) begin
      if (req_acc && req_payload.operation == OP_LOAD_RHS) begin
         rhs_mem[req_payload.row_index] <= req_payload.entry_value;
      end
      rhs_rd_ff <= rhs_mem[row_ff];
   end

   always_ff @(posedge clock) begin
      if (est_we && !est_wbank) begin
         est0_mem[row_ff] <= div_q;
      end
      if (est_we && est_wbank) begin
         est1_mem[row_ff] <= div_q;
      end
      est_rd_ff <= bank_ff ? est1_mem[col_ff] : est0_mem[col_ff];
   end

   // config registers
   always_comb begin
      iter_limit_in = iter_limit_ff;
      order_in = order_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            CSR_ITER_LIMIT: iter_limit_in = csr_pwdata[ITER_W-1:0];
            CSR_ORDER: order_in = csr_pwdata[ORDER_W-1:0];
            default: ;
         endcase
      end
      case (csr_paddr[2])
         CSR_ITER_LIMIT: csr_prdata = DATA_W'(iter_limit_ff);
         CSR_ORDER: csr_prdata = DATA_W'(order_ff);
         default: csr_prdata = '0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      row_in = row_ff;
      col_in = col_ff;
      sweep_in = sweep_ff;
      n_in = n_ff;
      err_in = err_ff;
      bank_in = bank_ff;
      init_in = init_ff;
      mac_ctrl = '0;
      div_start = 1'b0;
      est_we = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc && req_payload.operation == OP_START) begin
               row_in = '0;
               err_in = 1'b0;
               n_in = n_clamp;
               state_in = S_DIAG;
            end
         end
         S_DIAG: state_in = S_DIAG_CHK;
         S_DIAG_CHK: begin
            if (mat_rd_ff == '0) begin
               err_in = 1'b1;
            end
            if (last_row) begin
               row_in = '0;
               col_in = '0;
               sweep_in = '0;
               init_in = 1'b1;
               state_in = (err_ff || mat_rd_ff == '0) ? S_EMIT_RD : S_ROW_BEGIN;
            end else begin
               row_in = row_ff + 1'b1;
               state_in = S_DIAG;
            end
         end
         S_ROW_BEGIN: begin
            col_in = '0;
            state_in = S_ROW_LOAD;
         end
         S_ROW_LOAD: begin
            mac_ctrl.load = 1'b1;
            state_in = init_ff ? S_DIV_RD : S_TERM_RD;
         end
         S_TERM_RD: begin
            if (col_ff == row_ff) begin
               if (last_col) begin
                  state_in = S_DIV_RD;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end else begin
               state_in = S_TERM_MUL;
            end
         end
         S_TERM_MUL: begin
            mac_ctrl.mul = 1'b1;
            state_in = S_TERM_ACC;
         end
         S_TERM_ACC: begin
            mac_ctrl.sub = 1'b1;
            if (last_col) begin
               state_in = S_DIV_RD;
            end else begin
               col_in = col_ff + 1'b1;
               state_in = S_TERM_RD;
            end
         end
         S_DIV_RD: state_in = S_DIV_GO;
         S_DIV_GO: begin
            div_start = 1'b1;
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               est_we = 1'b1;
               if (last_row) begin
                  row_in = '0;
                  col_in = '0;
                  init_in = 1'b0;
                  if (!init_ff) begin
                     bank_in = ~bank_ff;
                     sweep_in = next_sweep;
                  end
                  state_in = (next_sweep < iter_limit_ff) ? S_ROW_BEGIN : S_EMIT_RD;
               end else begin
                  row_in = row_ff + 1'b1;
                  state_in = S_ROW_BEGIN;
               end
            end
         end
         S_EMIT_RD: state_in = S_EMIT_OUT;
         S_EMIT_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.unknown_index = col_ff;
               rsp_data_in.solution_value = err_ff ? '0 : est_rd_ff;
               rsp_data_in.last_entry = last_col;
               rsp_data_in.zero_diagonal_error = err_ff;
               if (last_col) begin
                  state_in = S_IDLE;
               end else begin
                  col_in = col_ff + 1'b1;
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff <= S_IDLE;
         row_ff <= '0;
         col_ff <= '0;
         sweep_ff <= '0;
         n_ff <= ORDER_W'(MAX_ORDER);
         err_ff <= 1'b0;
         bank_ff <= 1'b0;
         init_ff <= 1'b0;
         iter_limit_ff <= ITER_W'(1);
         order_ff <= ORDER_W'(MAX_ORDER);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff <= row_in;
         col_ff <= col_in;
         sweep_ff <= sweep_in;
         n_ff <= n_in;
         err_ff <= err_in;
         bank_ff <= bank_in;
         init_ff <= init_in;
         iter_limit_ff <= iter_limit_in;
         order_ff <= order_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   `JLS_ASSERT_NOW(a_div_done_waits, div_done, state_ff == S_DIV_WAIT, "divider result with no waiting sequencer")
   `JLS_ASSERT_NOW(a_no_diag_term, state_ff == S_TERM_ACC, col_ff != row_ff, "diagonal term accumulated")
   `JLS_ASSERT_NOW(a_err_zero, rsp_valid_ff && rsp_data_ff.zero_diagonal_error, rsp_data_ff.solution_value == '0, "nonzero value on error")
   `JLS_ASSERT_NEXT(a_start_stalls, req_acc && req_payload.operation == OP_START, req_stall, "input taken during solve")

endmodule
